[hw/rtl/kvt_pkg.sv]
// kvt_pkg: shared types and constants of the key/value table
// op codes, request and response words, cell command and chain link structs
// no dependencies
package kvt_pkg;

    localparam int KVT_CAPACITY = 64;
    localparam int WORD_W       = 32;
    localparam int ENTRY_W      = 7;
    localparam int OP_W         = 2;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_COMMIT = 2'b10
    } t_state;

    typedef struct packed {
        t_op   op;
        t_word key;
        t_word value;
    } t_req;

    typedef struct packed {
        t_word              result_value;
        logic               found;
        logic               table_full;
        logic [ENTRY_W-1:0] entry_count;
        logic               is_empty;
    } t_rsp;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic  search;
        t_word search_key;
        logic  commit;
        t_op   op;
        t_word key;
        t_word value;
        logic  any_hit;
    } t_cell_cmd;

    // handed from one cell to the next
    typedef struct packed {
        logic  hit;
        logic  free_seen;
        t_word value;
    } t_link;

endpackage

[hw/rtl/kvt_stream_if.sv]
// kvt_stream_if: valid/ready channel carrying one word of a given type
// no dependencies; the payload type is set by the instantiating level
interface kvt_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/key_value_table.sv]
// key_value_table: bounded dictionary of unique 32-bit keys with 32-bit values
// depends on kvt_pkg, kvt_stream_if and kvt_cell
//
// channels: i_req takes words {op, key, value}, o_rsp gives words
// {result_value, found, table_full, entry_count, is_empty}, i_cfg writes the
// absent value (always ready). op insert/update, lookup, remove; op 3 does nothing.
// timing: a request accepted at an edge has its compare done by all cells at
// that edge; the write-back and the response register load at the commit edge
// that follows, which sets o_rsp valid and waits while o_rsp is stalled; no new
// request is taken before that commit. the steps are the parallel compare in
// the cells and the write-back through the cell chain.
// stalls: i_req is accepted while an earlier response still waits on o_rsp;
// the write-back of that request holds until the response register is free.
// reset: all valid bits and the count clear in the reset cycle, the absent
// value returns to -1; no clearing pass is needed.
module key_value_table #(
    parameter int CAPACITY = kvt_pkg::KVT_CAPACITY
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kvt_stream_if.sink   i_req,
    kvt_stream_if.source o_rsp,
    kvt_stream_if.sink   i_cfg
);
    import kvt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state           r_state;
    t_state           n_state;
    t_op              r_op;
    t_word            r_key;
    t_word            r_value;
    t_word            r_absent;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_rsp_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;
    logic             accept;
    logic             commit;
    logic             any_hit;
    logic             has_free;
    logic             found;
    t_cell_cmd        cmd;
    t_link            link [CAPACITY+1];

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign accept      = i_req.valid && i_req.ready;
    assign commit      = (r_state == S_COMMIT) && (!r_rsp_valid || o_rsp.ready);

    assign any_hit  = link[CAPACITY].hit;
    assign has_free = link[CAPACITY].free_seen;

    assign cmd.search     = accept;
    assign cmd.search_key = i_req.data.key;
    assign cmd.commit     = commit;
    assign cmd.op         = r_op;
    assign cmd.key        = r_key;
    assign cmd.value      = r_value;
    assign cmd.any_hit    = any_hit;

    assign link[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        kvt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_link  (link[g]),
            .o_link  (link[g+1])
        );
    end

    always_comb begin
        found   = any_hit && (r_op != OP_NOP);
        n_count = r_count;
        unique case (r_op)
            OP_INSERT: begin
                if (!any_hit && has_free) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (any_hit) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_rsp.result_value = found ? link[CAPACITY].value : r_absent;
        n_rsp.found        = found;
        n_rsp.table_full   = (r_op == OP_INSERT) && !any_hit && !has_free;
        n_rsp.entry_count  = ENTRY_W'(n_count);
        n_rsp.is_empty     = (n_count == '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
            r_absent    <= '1;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_absent <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_req.data.op;
            r_key   <= i_req.data.key;
            r_value <= i_req.data.value;
        end
        if (commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule

[hw/rtl/kvt_cell.sv]
// kvt_cell: one slot of the table, key, value and valid bit
// compares on search, writes back on commit, chains hit/free/value to its neighbor
// depends on kvt_pkg
module kvt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kvt_pkg::t_cell_cmd i_cmd,
    input  kvt_pkg::t_link    i_link,
    output kvt_pkg::t_link    o_link
);
    import kvt_pkg::*;

    t_word r_key;
    t_word r_value;
    logic  r_valid;
    logic  r_hit;
    logic  r_free;
    logic  claim;

    // lowest free slot takes a new key
    assign claim = i_cmd.commit && (i_cmd.op == OP_INSERT) && !i_cmd.any_hit
                   && r_free && !i_link.free_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            if (i_cmd.search) begin
                r_hit  <= r_valid && (r_key == i_cmd.search_key);
                r_free <= !r_valid;
            end
            if (claim) begin
                r_valid <= 1'b1;
            end else if (i_cmd.commit && (i_cmd.op == OP_REMOVE) && r_hit) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (claim) begin
            r_key   <= i_cmd.key;
            r_value <= i_cmd.value;
        end else if (i_cmd.commit && (i_cmd.op == OP_INSERT) && r_hit) begin
            r_value <= i_cmd.value;
        end
    end

    assign o_link.hit       = i_link.hit | r_hit;
    assign o_link.free_seen = i_link.free_seen | r_free;
    assign o_link.value     = i_link.value | (r_hit ? r_value : '0);

endmodule

[hw/rtl/kvt_checker.sv]
// kvt_checker: port-level checks of the key/value table
// depends on kvt_pkg; bound to key_value_table below
module kvt_checker #(
    parameter int CAPACITY = kvt_pkg::KVT_CAPACITY
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input kvt_pkg::t_rsp i_rsp_data
);
    import kvt_pkg::*;

    localparam logic [ENTRY_W-1:0] CAP_CNT = ENTRY_W'(CAPACITY);
    localparam bit CAP_WRAPS = (CAPACITY >= (1 << ENTRY_W));

    // ready drops once a word is accepted
    a_req_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken on back-to-back cycles");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.is_empty == (i_rsp_data.entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_found_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_data.found && i_rsp_data.table_full))
        else $error("found and full together");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.table_full |-> CAP_WRAPS ||
        (i_rsp_data.entry_count == CAP_CNT))
        else $error("full reported below capacity");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled response changed");

endmodule

bind key_value_table kvt_checker #(
    .CAPACITY (CAPACITY)
) u_kvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
